// ===== rtl/sfa_pkg.sv =====
// Shared types and codes for the sparse fragment array.
// Used by the top, front and back modules; depends on nothing.
package sfa_pkg;

    localparam logic [2:0] KIND_SET    = 3'd0;
    localparam logic [2:0] KIND_GET    = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_FIND   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    typedef logic [2:0] t_op;
    localparam t_op OP_SET   = 3'd0;
    localparam t_op OP_GET   = 3'd1;
    localparam t_op OP_DEL   = 3'd2;
    localparam t_op OP_FIND  = 3'd3;
    localparam t_op OP_CLEAR = 3'd4;
    localparam t_op OP_RANGE = 3'd5;
    localparam t_op OP_NOP   = 3'd6;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RANGE  = 2'd1;
    localparam logic [1:0] STAT_UNUSED = 2'd2;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_SPAWN = 2'd1;
    localparam logic [1:0] EVT_FREE  = 2'd2;

    typedef struct packed {
        logic [2:0]          kind;
        logic signed [15:0]  index;
        logic signed [31:0]  key;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  value;
        logic                found;
        logic [1:0]          fragment_event;
        logic [3:0]          fragment_number;
        logic [8:0]          item_count;
        logic [8:0]          allocated_cells;
    } t_out;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  frag;
        logic [31:0] key;
    } t_cmd;

endpackage

// ===== rtl/sparse_fragment_array.sv =====
// Sparse fragment array: a flat cell space split into lazily used fragments.
// Input word: kind (set, get, delete, contains key, reset all), index, key.
// Output word: status, value, found, fragment event and number, cell counts.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Every input word gives exactly one output word, in order.
// With the back end idle, an accepted word passes through the command queue and
// the back end's IDLE and DONE states into the output register; get adds a READ
// state for the registered read of the cell RAM, and contains key adds a SCAN
// state that walks the cell RAM through its single read port.
// The back end handles one word at a time, finishing each before taking the next.
// A two-entry command queue keeps taking input words while the back end works
// or while a result waits in the output register.
// When the receiver stalls, the result holds and the back end waits once it has
// the next result ready; the queue then fills and the input side stalls.
// Synchronous reset clears all valid bits, counts and both handshakes;
// cell contents are only used while their valid bit is set.
// Depends on sfa_pkg, sfa_front, sfa_back and sfa_ram.
module sparse_fragment_array #(
    parameter int N_FRAGS  = 16,
    parameter int FRAG_LEN = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfa_pkg::t_in  i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sfa_pkg::t_out o_out_word
);
    import sfa_pkg::*;

    localparam int TOTAL = N_FRAGS * FRAG_LEN;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    logic          cmd_valid;
    t_cmd          cmd;
    logic          pop;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    sfa_front #(
        .N_FRAGS (N_FRAGS),
        .FRAG_LEN(FRAG_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_pop      (pop)
    );

    sfa_back #(
        .N_FRAGS (N_FRAGS),
        .FRAG_LEN(FRAG_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_pop      (pop),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    sfa_ram #(
        .WIDTH(32),
        .DEPTH(TOTAL)
    ) u_cells (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    a_err_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != STAT_OK) |->
            (o_out_word.fragment_event == EVT_NONE))
        else $error("fragment event on a failed item");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.found) |-> (o_out_word.status == STAT_OK))
        else $error("found set with error status");

    a_value_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.value != 32'sd0) |-> o_out_word.found)
        else $error("value returned without a hit");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid)
        else $error("back end popped an empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

// ===== rtl/sfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                    i_wr_data,
    input  logic                                i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                    o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/sfa_front.sv =====
// Front end: accepts input words, range-checks and decodes them into commands,
// and holds them in a two-entry queue for the back end. Depends on sfa_pkg.
module sfa_front #(
    parameter int N_FRAGS  = 16,
    parameter int FRAG_LEN = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfa_pkg::t_in  i_in_word,
    output logic          o_cmd_valid,
    output sfa_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import sfa_pkg::*;

    localparam int TOTAL = N_FRAGS * FRAG_LEN;
    // index / FRAG_LEN as multiply by a rounded-up reciprocal
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / FRAG_LEN + 1);

    logic [15:0] idx_u;
    logic        in_range;
    logic [48:0] prod;
    t_cmd        cmd;
    logic        push;

    t_cmd        r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    assign idx_u    = i_in_word.index;
    assign in_range = !idx_u[15] && (17'(idx_u) < 17'(TOTAL));
    assign prod     = 49'(idx_u) * 49'(RECIP);

    always_comb begin
        cmd.addr = idx_u;
        cmd.frag = prod[32 +: 8];
        cmd.key  = i_in_word.key;
        unique case (i_in_word.kind)
            KIND_SET:    cmd.op = in_range ? OP_SET : OP_RANGE;
            KIND_GET:    cmd.op = in_range ? OP_GET : OP_RANGE;
            KIND_DELETE: cmd.op = in_range ? OP_DEL : OP_RANGE;
            KIND_FIND:   cmd.op = OP_FIND;
            KIND_CLEAR:  cmd.op = OP_CLEAR;
            default:     cmd.op = OP_NOP;
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end
endmodule

// ===== rtl/sfa_back.sv =====
// Back end: executes queued commands against the valid bits, fragment counts
// and the cell RAM, and holds the result word. Depends on sfa_pkg.
module sfa_back #(
    parameter int N_FRAGS  = 16,
    parameter int FRAG_LEN = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sfa_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_wr_en,
    output logic [((N_FRAGS * FRAG_LEN) > 1 ?
                   $clog2(N_FRAGS * FRAG_LEN) : 1)-1:0] o_wr_addr,
    output logic [31:0]   o_wr_data,
    output logic          o_rd_en,
    output logic [((N_FRAGS * FRAG_LEN) > 1 ?
                   $clog2(N_FRAGS * FRAG_LEN) : 1)-1:0] o_rd_addr,
    input  logic [31:0]   i_rd_data,
    output logic          o_out_valid,
    output sfa_pkg::t_out o_out_word,
    input  logic          i_out_stall
);
    import sfa_pkg::*;

    localparam int TOTAL = N_FRAGS * FRAG_LEN;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int FW    = (N_FRAGS > 1) ? $clog2(N_FRAGS) : 1;
    localparam int CW    = $clog2(FRAG_LEN + 1);
    localparam int TW    = $clog2(TOTAL + 1);
    localparam int NW    = $clog2(N_FRAGS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]     r_state;
    logic [TOTAL-1:0] r_valid;
    logic [CW-1:0]  r_cnt [N_FRAGS];
    logic [TW-1:0]  r_total;
    logic [NW-1:0]  r_active;
    logic [31:0]    r_key;
    logic [AW:0]    r_scan;
    logic           r_chk_pend;
    logic [AW-1:0]  r_chk_addr;
    t_out           r_res;
    t_out           r_out;
    logic           r_out_valid;
    t_out           n_res;
    t_out           n_out;

    logic [AW-1:0]  cell_addr;
    logic [FW-1:0]  frag;
    logic           cur_valid;
    logic [CW-1:0]  cur_cnt;
    logic           scan_more;
    logic           scan_hit;
    logic           slot_free;

    assign cell_addr = i_cmd.addr[AW-1:0];
    assign frag      = i_cmd.frag[FW-1:0];
    assign cur_valid = r_valid[cell_addr];
    assign cur_cnt   = r_cnt[frag];
    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign scan_more = r_scan < (AW + 1)'(TOTAL);
    assign scan_hit  = r_chk_pend && r_valid[r_chk_addr] && (i_rd_data == r_key);
    assign slot_free = !r_out_valid || !i_out_stall;

    assign o_wr_en   = o_pop && (i_cmd.op == OP_SET);
    assign o_wr_addr = cell_addr;
    assign o_wr_data = i_cmd.key;
    assign o_rd_en   = (o_pop && (i_cmd.op == OP_GET)) || ((r_state == S_SCAN) && scan_more);
    assign o_rd_addr = (r_state == S_SCAN) ? r_scan[AW-1:0] : cell_addr;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // result fields known when the command is taken
    always_comb begin
        n_res = '0;
        unique case (i_cmd.op)
            OP_SET: begin
                n_res.fragment_number = 4'(i_cmd.frag);
                if (!cur_valid && cur_cnt == '0) begin
                    n_res.fragment_event = EVT_SPAWN;
                end
            end
            OP_GET: begin
                n_res.fragment_number = 4'(i_cmd.frag);
                n_res.found           = cur_valid;
                n_res.status          = cur_valid ? STAT_OK : STAT_UNUSED;
            end
            OP_DEL: begin
                n_res.fragment_number = 4'(i_cmd.frag);
                if (!cur_valid || cur_cnt == '0) begin
                    n_res.status = STAT_UNUSED;
                end else if (cur_cnt == CW'(1)) begin
                    n_res.fragment_event = EVT_FREE;
                end
            end
            OP_RANGE: begin
                n_res.status = STAT_RANGE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out                 = r_res;
        n_out.item_count      = 9'(r_total);
        n_out.allocated_cells = 9'(r_active * FRAG_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cnt       <= '{default: '0};
            r_total     <= '0;
            r_active    <= '0;
            r_chk_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_DONE) && slot_free) ||
                           (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_res   <= n_res;
                        r_key   <= i_cmd.key;
                        r_state <= (i_cmd.op == OP_GET)  ? S_READ :
                                   (i_cmd.op == OP_FIND) ? S_SCAN : S_DONE;
                        unique case (i_cmd.op)
                            OP_SET: begin
                                if (!cur_valid) begin
                                    r_valid[cell_addr] <= 1'b1;
                                    r_cnt[frag]        <= cur_cnt + CW'(1);
                                    r_total            <= r_total + TW'(1);
                                    if (cur_cnt == '0) begin
                                        r_active <= r_active + NW'(1);
                                    end
                                end
                            end
                            OP_DEL: begin
                                if (cur_valid && cur_cnt != '0) begin
                                    r_valid[cell_addr] <= 1'b0;
                                    r_cnt[frag]        <= cur_cnt - CW'(1);
                                    r_total            <= r_total - TW'(1);
                                    if (cur_cnt == CW'(1)) begin
                                        r_active <= r_active - NW'(1);
                                    end
                                end
                            end
                            OP_FIND: begin
                                r_scan     <= '0;
                                r_chk_pend <= 1'b0;
                            end
                            OP_CLEAR: begin
                                r_valid  <= '0;
                                r_cnt    <= '{default: '0};
                                r_total  <= '0;
                                r_active <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (r_res.found) begin
                        r_res.value <= i_rd_data;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_res.found <= 1'b1;
                        r_chk_pend  <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (!r_chk_pend && !scan_more) begin
                        r_state <= S_DONE;
                    end else if (scan_more) begin
                        r_chk_pend <= 1'b1;
                        r_chk_addr <= r_scan[AW-1:0];
                        r_scan     <= r_scan + (AW + 1)'(1);
                    end else begin
                        r_chk_pend <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
